>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/cqs_pkg.sv
package cqs_pkg;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ_RD,
    ST_SEARCH
  } state_t;

endpackage

>>> rtl/circular_queue_with_search.sv
// Circular FIFO of signed 32-bit words with a linear search.
// Input channel (in_valid/in_ready): action (enqueue, dequeue, search) and
// data_value (word to store or key to look for). Output channel
// (out_valid/out_ready): exactly one result item per input item, in order,
// with data_out, found, status, front_value, rear_value and occupancy.
// Words live in a DEPTH x 32 synchronous RAM with one write and one read port.
// Path from accept to result valid:
//   enqueue, dequeue of the last word, rejected ops, unused code: no RAM read
//   dequeue leaving words behind: RAM read of the new front (ST_DEQ_RD)
//   search: reads from the oldest entry on; stops at the first match
// The RAM read port paces the search: one entry is read per cycle.
// One item is in flight at a time; in_ready is high only when the
// sequencer is idle and the result register is empty or being drained.
// A stalled receiver holds the result and thus holds off new items.
// Reset (rst, synchronous) empties the queue: head at zero, tail at
// DEPTH-1, count zero. RAM contents are not cleared and need no sweep.
`include "assert_macros.svh"

module circular_queue_with_search #(
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [cqs_pkg::ACTION_W-1:0]    action,
  input  logic signed [cqs_pkg::DATA_W-1:0]      data_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cqs_pkg::DATA_W-1:0]      data_out,
  output logic                                   found,
  output logic        [cqs_pkg::STATUS_W-1:0]    status,
  output logic signed [cqs_pkg::DATA_W-1:0]      front_value,
  output logic signed [cqs_pkg::DATA_W-1:0]      rear_value,
  output logic        [cqs_pkg::OCC_W-1:0]       occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Wrap-around increment of a queue index
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Entry RAM
  logic [cqs_pkg::DATA_W-1:0] mem [DEPTH];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [cqs_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [cqs_pkg::DATA_W-1:0] rd_data;

  // Control state
  cqs_pkg::state_t state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [AW-1:0]   tail, tail_next;
  logic [CW-1:0]   count, count_next;
  logic            out_valid_next;

  // Cached end words and search walk
  logic [cqs_pkg::DATA_W-1:0] front_word, front_word_next;
  logic [cqs_pkg::DATA_W-1:0] rear_word, rear_word_next;
  logic [cqs_pkg::DATA_W-1:0] key, key_next;
  logic [AW-1:0]              scan_pos, scan_pos_next;
  logic [CW-1:0]              scan_left, scan_left_next;

  // Result register next values
  logic [cqs_pkg::DATA_W-1:0]   data_out_next;
  logic                         found_next;
  logic [cqs_pkg::STATUS_W-1:0] status_next;
  logic [cqs_pkg::DATA_W-1:0]   front_value_next;
  logic [cqs_pkg::DATA_W-1:0]   rear_value_next;
  logic [cqs_pkg::OCC_W-1:0]    occupancy_next;

  logic accept;
  logic is_full;
  logic is_empty;
  logic key_hit;
  logic enq_grow;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign accept   = in_valid && in_ready;
  assign key_hit  = (rd_data == key);
  assign enq_grow = accept && (action == cqs_pkg::ACT_ENQUEUE) && !is_full;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      cqs_pkg::ST_IDLE: begin
        if (accept) begin
          if (action == cqs_pkg::ACT_DEQUEUE && count > CW'(1)) begin
            state_next = cqs_pkg::ST_DEQ_RD;
          end else if (action == cqs_pkg::ACT_SEARCH && !is_empty) begin
            state_next = cqs_pkg::ST_SEARCH;
          end
        end
      end
      cqs_pkg::ST_DEQ_RD: begin
        state_next = cqs_pkg::ST_IDLE;
      end
      cqs_pkg::ST_SEARCH: begin
        if (key_hit || scan_left == '0) begin
          state_next = cqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cqs_pkg::ST_IDLE;
      end
    endcase
  end

  // Output and datapath logic
  always_comb begin
    in_ready         = (state == cqs_pkg::ST_IDLE) && (!out_valid || out_ready);
    mem_we           = 1'b0;
    mem_waddr        = idx_inc(tail);
    mem_wdata        = data_value;
    mem_re           = 1'b0;
    mem_raddr        = head;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    front_word_next  = front_word;
    rear_word_next   = rear_word;
    key_next         = key;
    scan_pos_next    = scan_pos;
    scan_left_next   = scan_left;
    out_valid_next   = out_valid && !out_ready;
    data_out_next    = data_out;
    found_next       = found;
    status_next      = status;
    front_value_next = front_value;
    rear_value_next  = rear_value;
    occupancy_next   = occupancy;

    case (state)
      cqs_pkg::ST_IDLE: begin
        if (accept) begin
          data_out_next = '0;
          found_next    = 1'b0;
          status_next   = cqs_pkg::STAT_OK;
          case (action)
            cqs_pkg::ACT_ENQUEUE: begin
              if (is_full) begin
                status_next = cqs_pkg::STAT_FULL;
              end else begin
                mem_we         = 1'b1;
                tail_next      = idx_inc(tail);
                count_next     = count + 1'b1;
                rear_word_next = data_value;
                if (is_empty) begin
                  front_word_next = data_value;
                end
              end
            end
            cqs_pkg::ACT_DEQUEUE: begin
              if (is_empty) begin
                status_next = cqs_pkg::STAT_EMPTY;
              end else begin
                data_out_next = front_word;
                head_next     = idx_inc(head);
                count_next    = count - 1'b1;
                // fetch the new front word
                mem_re        = (count > CW'(1));
                mem_raddr     = idx_inc(head);
              end
            end
            cqs_pkg::ACT_SEARCH: begin
              if (is_empty) begin
                status_next = cqs_pkg::STAT_EMPTY;
              end else begin
                // start the walk at the oldest entry
                mem_re         = 1'b1;
                mem_raddr      = head;
                key_next       = data_value;
                scan_pos_next  = idx_inc(head);
                scan_left_next = count - 1'b1;
              end
            end
            default: begin
            end
          endcase
          // result complete now unless a RAM read is still needed
          out_valid_next   = !mem_re;
          occupancy_next   = cqs_pkg::OCC_W'(count_next);
          front_value_next = (count_next == '0) ? '0 : front_word_next;
          rear_value_next  = (count_next == '0) ? '0 : rear_word_next;
        end
      end
      cqs_pkg::ST_DEQ_RD: begin
        front_word_next  = rd_data;
        front_value_next = rd_data;
        out_valid_next   = 1'b1;
      end
      cqs_pkg::ST_SEARCH: begin
        if (key_hit || scan_left == '0) begin
          found_next     = key_hit;
          out_valid_next = 1'b1;
        end else begin
          mem_re         = 1'b1;
          mem_raddr      = scan_pos;
          scan_pos_next  = idx_inc(scan_pos);
          scan_left_next = scan_left - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cqs_pkg::ST_IDLE;
      head      <= '0;
      tail      <= AW'(DEPTH - 1);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    front_word  <= front_word_next;
    rear_word   <= rear_word_next;
    key         <= key_next;
    scan_pos    <= scan_pos_next;
    scan_left   <= scan_left_next;
    data_out    <= data_out_next;
    found       <= found_next;
    status      <= status_next;
    front_value <= front_value_next;
    rear_value  <= rear_value_next;
    occupancy   <= occupancy_next;
  end

  // Checks
  `ASSERT_IMPL(a_count_in_range, 1'b1, count <= CW'(DEPTH))
  `ASSERT_IMPL(a_busy_no_result, state != cqs_pkg::ST_IDLE, !out_valid)
  `ASSERT_IMPL(a_ready_slot_free, in_ready, !out_valid || out_ready)
  `ASSERT_NEXT(a_enq_grows, enq_grow, count == $past(count) + 1'b1)

endmodule
